// File: rtl/lz77tsw_pkg.sv
package lz77tsw_pkg;

    // Walker phase codes
    localparam logic [1:0] PH_FLAG  = 2'd0;
    localparam logic [1:0] PH_TOKEN = 2'd1;
    localparam logic [1:0] PH_REF2  = 2'd2;

    // Byte role codes
    localparam logic [2:0] ROLE_FLAG    = 3'd0;
    localparam logic [2:0] ROLE_LIT     = 3'd1;
    localparam logic [2:0] ROLE_REF1    = 3'd2;
    localparam logic [2:0] ROLE_REF2    = 3'd3;
    localparam logic [2:0] ROLE_IGNORED = 3'd4;

    localparam logic [3:0] TOKENS_PER_FLAG = 4'd8;
    localparam logic [4:0] MIN_MATCH       = 5'd3;

    // Walker state carried from one byte to the next
    typedef struct packed {
        logic [1:0]  phase;
        logic [7:0]  flag_bits;
        logic [3:0]  tokens_left;
        logic [23:0] bytes_left;
        logic [4:0]  pending_length;
        logic [3:0]  offset_high;
        logic        finished;
        logic        overrun_seen;
    } walk_state_t;

    // One result item
    typedef struct packed {
        logic [2:0]  byte_role;
        logic [7:0]  literal_value;
        logic        token_done;
        logic [4:0]  match_length;
        logic [11:0] match_offset;
        logic [23:0] remaining;
        logic        stream_end;
        logic        overrun;
    } walk_result_t;

    // State right after reset or a length write
    function automatic walk_state_t restart_state(input logic [23:0] total_length);
        walk_state_t st;
        st.phase          = PH_FLAG;
        st.flag_bits      = 8'd0;
        st.tokens_left    = 4'd0;
        st.bytes_left     = total_length;
        st.pending_length = 5'd0;
        st.offset_high    = 4'd0;
        st.finished       = (total_length == 24'd0);
        st.overrun_seen   = 1'b0;
        return st;
    endfunction

endpackage

// File: rtl/lz77tsw_step.sv
module lz77tsw_step
    import lz77tsw_pkg::*;
(
    input  walk_state_t  cur_state,
    input  logic [7:0]   data_byte,
    output walk_state_t  next_state,
    output walk_result_t result
);

    logic        advance;
    logic [23:0] pend_wide;

    assign pend_wide = {19'd0, cur_state.pending_length};

    always_comb begin
        next_state           = cur_state;
        advance              = 1'b0;
        result.byte_role     = ROLE_IGNORED;
        result.literal_value = 8'd0;
        result.token_done    = 1'b0;
        result.match_length  = 5'd0;
        result.match_offset  = 12'd0;

        // Decode one byte according to the current phase
        if (!cur_state.finished) begin
            case (cur_state.phase)
                PH_TOKEN: begin
                    if (!cur_state.flag_bits[7]) begin
                        result.byte_role     = ROLE_LIT;
                        result.literal_value = data_byte;
                        result.token_done    = 1'b1;
                        if (cur_state.bytes_left != 24'd0) begin
                            next_state.bytes_left = cur_state.bytes_left - 24'd1;
                        end
                        advance = 1'b1;
                    end else begin
                        result.byte_role          = ROLE_REF1;
                        next_state.pending_length = {1'b0, data_byte[7:4]} + MIN_MATCH;
                        next_state.offset_high    = data_byte[3:0];
                        next_state.phase          = PH_REF2;
                    end
                end
                PH_REF2: begin
                    result.byte_role    = ROLE_REF2;
                    result.token_done   = 1'b1;
                    result.match_length = cur_state.pending_length;
                    result.match_offset = {cur_state.offset_high, data_byte};
                    // Saturate the count when the copy runs past the end
                    if (pend_wide > cur_state.bytes_left) begin
                        next_state.overrun_seen = 1'b1;
                        next_state.bytes_left   = 24'd0;
                    end else begin
                        next_state.bytes_left = cur_state.bytes_left - pend_wide;
                    end
                    advance = 1'b1;
                end
                default: begin
                    result.byte_role       = ROLE_FLAG;
                    next_state.flag_bits   = data_byte;
                    next_state.tokens_left = TOKENS_PER_FLAG;
                    next_state.phase       = PH_TOKEN;
                end
            endcase
        end

        // Step to the next token slot of the flag byte
        if (advance) begin
            next_state.flag_bits = {cur_state.flag_bits[6:0], 1'b0};
            if (cur_state.tokens_left != 4'd0) begin
                next_state.tokens_left = cur_state.tokens_left - 4'd1;
            end
            if (next_state.bytes_left == 24'd0) begin
                next_state.finished = 1'b1;
            end
            next_state.phase = (next_state.tokens_left == 4'd0) ? PH_FLAG : PH_TOKEN;
        end

        result.remaining  = next_state.finished ? 24'd0 : next_state.bytes_left;
        result.stream_end = next_state.finished;
        result.overrun    = next_state.overrun_seen;
    end

endmodule

// File: rtl/lz77_token_stream_walker.sv
// LZ77 (type 0x10) token stream walker.
// Input channel (s_valid/s_ready/s_data_byte): compressed bytes following the
// stream header, one request per byte. Output channel (m_valid/m_ready/m_*):
// one result per input byte giving its role (flag, literal, reference first
// or second byte, ignored after end), the literal or match length/offset,
// the remaining decompressed count, end of stream and the sticky overrun flag.
// Configuration: cfg_wr_en/cfg_wr_data write the decompressed length; each
// write restarts the walk. Write it only while no request is in flight.
// Each accepted byte's result is registered in the output or skid register.
// Throughput is one byte per cycle while the skid entry is empty; the state
// update is a single combinational step between state registers and output.
// A two-entry output stage (output register plus skid register) lets the
// block keep taking bytes while a result waits; when the receiver stalls the
// skid entry fills and s_ready drops until the output drains.
// Reset clears both output entries and loads a zero length, so the walker
// starts finished and marks every byte ignored until a length is written.
module lz77_token_stream_walker
    import lz77tsw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [23:0] cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_byte_role,
    output logic [7:0]  m_literal_value,
    output logic        m_token_done,
    output logic [4:0]  m_match_length,
    output logic [11:0] m_match_offset,
    output logic [23:0] m_remaining,
    output logic        m_stream_end,
    output logic        m_overrun
);

    walk_state_t  state_reg;
    walk_state_t  state_next;
    walk_result_t step_result;

    walk_result_t out_reg;
    logic         out_valid_reg;
    walk_result_t skid_reg;
    logic         skid_valid_reg;

    logic         in_fire;
    logic         out_fire;

    assign s_ready  = !skid_valid_reg;
    assign in_fire  = s_valid && s_ready;
    assign out_fire = out_valid_reg && m_ready;

    lz77tsw_step u_step (
        .cur_state  (state_reg),
        .data_byte  (s_data_byte),
        .next_state (state_next),
        .result     (step_result)
    );

    // Walker state: restart on reset or length write, step on each request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= restart_state(24'd0);
        end else if (cfg_wr_en) begin
            state_reg <= restart_state(cfg_wr_data);
        end else if (in_fire) begin
            state_reg <= state_next;
        end
    end

    // Output valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || out_fire) begin
                out_valid_reg  <= skid_valid_reg || in_fire;
                skid_valid_reg <= 1'b0;
            end else if (in_fire) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Output payload: skid entry drains first to keep order
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_fire) begin
            out_reg <= skid_valid_reg ? skid_reg : step_result;
        end
        if (in_fire && out_valid_reg && !out_fire) begin
            skid_reg <= step_result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_byte_role     = out_reg.byte_role;
    assign m_literal_value = out_reg.literal_value;
    assign m_token_done    = out_reg.token_done;
    assign m_match_length  = out_reg.match_length;
    assign m_match_offset  = out_reg.match_offset;
    assign m_remaining     = out_reg.remaining;
    assign m_stream_end    = out_reg.stream_end;
    assign m_overrun       = out_reg.overrun;

endmodule
